// ===== rtl/core/quaternion_vector_rotate_assert.svh =====
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_assert.svh
// Assertion macros for the quaternion vector rotation block. Both macros
// sample on clk and are disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_VECTOR_ROTATE_ASSERT_SVH
`define QUATERNION_VECTOR_ROTATE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define QVR_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qvr assertion failed");

// next-cycle implication
`define QVR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qvr assertion failed");

`else

`define QVR_ASSERT_IMPLY(label, ante, cons)

`define QVR_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/core/qvr_pkg.sv =====
// ----------------------------------------------------------------------------
// qvr_pkg
// Shared types and constants of the quaternion vector rotation block.
// ----------------------------------------------------------------------------
package qvr_pkg;

  // quaternion component width, fixed by the item format
  localparam int QUAT_W = 16;
  // exact product of two quaternion components
  localparam int QPROD_W = 2 * QUAT_W;
  // one matrix entry: 2*(a*b +/- c*d) held exactly
  localparam int ENT_W = QPROD_W + 2;
  // rotated component width and its rails
  localparam int ROT_W = 17;
  localparam int ROT_MAX = 65535;
  localparam int ROT_MIN = -65536;

  typedef logic signed [QUAT_W-1:0]  quat_t;
  typedef logic signed [QPROD_W-1:0] qprod_t;
  typedef logic signed [ENT_W-1:0]   entry_t;
  typedef logic signed [ROT_W-1:0]   rot_t;

  localparam rot_t ROT_HI = ROT_W'(ROT_MAX);
  localparam rot_t ROT_LO = ROT_W'(ROT_MIN);

  // load strobes for the two matrix stages
  typedef struct packed {
    logic load_prod;
    logic load_mat;
  } stage_ctl_t;

endpackage

// ===== rtl/core/qvr_in_if.sv =====
// ----------------------------------------------------------------------------
// qvr_in_if
// Input channel: rotation quaternion and vector, valid/ready handshake.
// ----------------------------------------------------------------------------
interface qvr_in_if import qvr_pkg::*; #(
  parameter int VEC_WIDTH = 16
) ();

  logic                        valid;
  logic                        ready;
  quat_t                       quat_w;
  quat_t                       quat_x;
  quat_t                       quat_y;
  quat_t                       quat_z;
  logic signed [VEC_WIDTH-1:0] vec_x;
  logic signed [VEC_WIDTH-1:0] vec_y;
  logic signed [VEC_WIDTH-1:0] vec_z;

  modport source (
    output valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
    input  ready
  );

  modport sink (
    input  valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
    output ready
  );

endinterface

// ===== rtl/core/qvr_out_if.sv =====
// ----------------------------------------------------------------------------
// qvr_out_if
// Output channel: rotated vector and clip flag, valid/ready handshake.
// ----------------------------------------------------------------------------
interface qvr_out_if import qvr_pkg::*; ();

  logic valid;
  logic ready;
  rot_t rot_x;
  rot_t rot_y;
  rot_t rot_z;
  logic clipped;

  modport source (
    output valid, rot_x, rot_y, rot_z, clipped,
    input  ready
  );

  modport sink (
    input  valid, rot_x, rot_y, rot_z, clipped,
    output ready
  );

endinterface

// ===== rtl/core/qvr_matrix.sv =====
// ----------------------------------------------------------------------------
// qvr_matrix
// Two register stages that turn a quaternion into the off-identity part of
// its rotation matrix: component products, then 2*(..) combinations.
// ----------------------------------------------------------------------------
module qvr_matrix import qvr_pkg::*; (
  input  logic       clk,
  input  stage_ctl_t ctl,
  input  quat_t      quat_w,
  input  quat_t      quat_x,
  input  quat_t      quat_y,
  input  quat_t      quat_z,
  output entry_t     mat [3][3]
);

  qprod_t xx, yy, zz, xy, xz, yz, wx, wy, wz;

  // stage 1: component products
  always_ff @(posedge clk) begin
    if (ctl.load_prod) begin
      xx <= quat_x * quat_x;
      yy <= quat_y * quat_y;
      zz <= quat_z * quat_z;
      xy <= quat_x * quat_y;
      xz <= quat_x * quat_z;
      yz <= quat_y * quat_z;
      wx <= quat_w * quat_x;
      wy <= quat_w * quat_y;
      wz <= quat_w * quat_z;
    end
  end

  // stage 2: matrix entries, identity part left to the vector add
  always_ff @(posedge clk) begin
    if (ctl.load_mat) begin
      mat[0][0] <= -((ENT_W'(yy) + ENT_W'(zz)) <<< 1);
      mat[0][1] <= (ENT_W'(xy) - ENT_W'(wz)) <<< 1;
      mat[0][2] <= (ENT_W'(wy) + ENT_W'(xz)) <<< 1;
      mat[1][0] <= (ENT_W'(xy) + ENT_W'(wz)) <<< 1;
      mat[1][1] <= -((ENT_W'(xx) + ENT_W'(zz)) <<< 1);
      mat[1][2] <= (ENT_W'(yz) - ENT_W'(wx)) <<< 1;
      mat[2][0] <= (ENT_W'(xz) - ENT_W'(wy)) <<< 1;
      mat[2][1] <= (ENT_W'(wx) + ENT_W'(yz)) <<< 1;
      mat[2][2] <= -((ENT_W'(xx) + ENT_W'(yy)) <<< 1);
    end
  end

endmodule

// ===== rtl/core/quaternion_vector_rotate.sv =====
// ----------------------------------------------------------------------------
// quaternion_vector_rotate
// Throughput: one item per cycle; a stalled output fills empty stages first.
// Stages: quaternion products, matrix entries, matrix-vector products,
//   row sums with rounding, round/saturate into the output register.
// Reset: rst (synchronous) clears all stage valid bits; data is not reset.
// ----------------------------------------------------------------------------
`include "quaternion_vector_rotate_assert.svh"

module quaternion_vector_rotate import qvr_pkg::*; #(
  parameter int QUAT_FRAC_BITS = 14,
  parameter int VEC_WIDTH      = 16
) (
  input logic      clk,
  input logic      rst,
  qvr_in_if.sink   req,
  qvr_out_if.source rsp
);

  localparam int NSTAGE    = 5;
  localparam int SHIFT     = 2 * QUAT_FRAC_BITS;
  localparam int PROD_W    = ENT_W + VEC_WIDTH;
  localparam int SUM_RAW_W = PROD_W + 2;
  localparam int SUM_W     = (SUM_RAW_W > SHIFT + 2) ? SUM_RAW_W : SHIFT + 2;
  localparam int QUO_W     = SUM_W - SHIFT;
  localparam int RES_B_W   = (QUO_W > VEC_WIDTH) ? QUO_W : VEC_WIDTH;
  localparam int RES_W     = ((RES_B_W > ROT_W) ? RES_B_W : ROT_W) + 1;

  localparam logic signed [SUM_W-1:0] HALF    = SUM_W'(1) << (SHIFT - 1);
  localparam logic signed [RES_W-1:0] RES_MAX = RES_W'(ROT_MAX);
  localparam logic signed [RES_W-1:0] RES_MIN = RES_W'(ROT_MIN);

  typedef logic signed [VEC_WIDTH-1:0] vec_t;
  typedef logic signed [PROD_W-1:0]    prod_t;
  typedef logic signed [SUM_W-1:0]     sum_t;
  typedef logic signed [RES_W-1:0]     res_t;

  logic [NSTAGE-1:0] stage_vld;
  logic [NSTAGE-1:0] en;
  stage_ctl_t        mat_ctl;
  entry_t            mat [3][3];
  vec_t              vec_pipe [4][3];
  prod_t             prod [3][3];
  sum_t              row_sum [3];
  res_t              res [3];
  rot_t              rot_next [3];
  logic [2:0]        clip_next;

  // stage advance: a stage moves when empty or when the next one moves
  always_comb begin
    en[NSTAGE-1] = !stage_vld[NSTAGE-1] || rsp.ready;
    for (int i = NSTAGE - 2; i >= 0; i--) begin
      en[i] = !stage_vld[i] || en[i+1];
    end
  end

  assign req.ready = en[0];
  assign rsp.valid = stage_vld[NSTAGE-1];

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_vld <= '0;
    end else begin
      if (en[0]) stage_vld[0] <= req.valid;
      for (int i = 1; i < NSTAGE; i++) begin
        if (en[i]) stage_vld[i] <= stage_vld[i-1];
      end
    end
  end

  // quaternion to matrix entries, stages 1 and 2
  assign mat_ctl.load_prod = en[0];
  assign mat_ctl.load_mat  = en[1];

  qvr_matrix u_matrix (
    .clk    (clk),
    .ctl    (mat_ctl),
    .quat_w (req.quat_w),
    .quat_x (req.quat_x),
    .quat_y (req.quat_y),
    .quat_z (req.quat_z),
    .mat    (mat)
  );

  // vector carried alongside the matrix stages
  always_ff @(posedge clk) begin
    if (en[0]) begin
      vec_pipe[0][0] <= VEC_WIDTH'(req.vec_x);
      vec_pipe[0][1] <= VEC_WIDTH'(req.vec_y);
      vec_pipe[0][2] <= VEC_WIDTH'(req.vec_z);
    end
    for (int s = 1; s < 4; s++) begin
      if (en[s]) vec_pipe[s] <= vec_pipe[s-1];
    end
  end

  // stage 3: matrix entry times vector component
  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod[r][c] <= PROD_W'(mat[r][c]) * PROD_W'(vec_pipe[1][c]);
        end
      end
    end
  end

  // stage 4: row sums plus rounding half
  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int r = 0; r < 3; r++) begin
        row_sum[r] <= SUM_W'(prod[r][0]) + SUM_W'(prod[r][1]) + SUM_W'(prod[r][2]) + HALF;
      end
    end
  end

  // stage 5: drop fraction, add identity part, saturate
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      res[r] = RES_W'(vec_pipe[3][r]) + RES_W'($signed(row_sum[r][SUM_W-1:SHIFT]));
      if (res[r] > RES_MAX) begin
        rot_next[r]  = ROT_HI;
        clip_next[r] = 1'b1;
      end else if (res[r] < RES_MIN) begin
        rot_next[r]  = ROT_LO;
        clip_next[r] = 1'b1;
      end else begin
        rot_next[r]  = ROT_W'(res[r]);
        clip_next[r] = 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en[4]) begin
      rsp.rot_x   <= rot_next[0];
      rsp.rot_y   <= rot_next[1];
      rsp.rot_z   <= rot_next[2];
      rsp.clipped <= |clip_next;
    end
  end

  // checks
  `QVR_ASSERT_IMPLY(a_clip_on_rail, rsp.valid && rsp.clipped,
    rsp.rot_x == ROT_HI || rsp.rot_x == ROT_LO || rsp.rot_y == ROT_HI ||
    rsp.rot_y == ROT_LO || rsp.rot_z == ROT_HI || rsp.rot_z == ROT_LO)
  `QVR_ASSERT_NEXT(a_accept_lands, req.valid && req.ready, stage_vld[0])
  `QVR_ASSERT_NEXT(a_stall_keeps_item, stage_vld[2] && !en[2], stage_vld[2])
  `QVR_ASSERT_IMPLY(a_ready_with_bubble, !(&stage_vld), req.ready)

endmodule

// ===== sim/quaternion_vector_rotate_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_tb
// Self-checking bench for the quaternion vector rotation pipeline. Items are
// pushed through the request channel with random gaps, results are taken with
// random back-pressure, and each result is compared against a bit-exact
// integer model of the rotation, rounding and saturation.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate_tb;
  import qvr_pkg::*;

  localparam int QUAT_FRAC = 14;
  localparam int VEC_W     = 16;
  localparam int N_RANDOM  = 1600;

  typedef logic signed [VEC_W-1:0] vec_t;

  // one request item
  typedef struct {
    quat_t quat_w;
    quat_t quat_x;
    quat_t quat_y;
    quat_t quat_z;
    vec_t  vec_x;
    vec_t  vec_y;
    vec_t  vec_z;
  } rot_req_t;

  // one rotated result
  typedef struct {
    rot_t rot_x;
    rot_t rot_y;
    rot_t rot_z;
    logic clipped;
  } rotated_t;

  // expected rotations in flight and the mismatch count
  class rotation_checker;
    rotated_t expected_rot_q[$];
    int       mismatches;

    function new();
      mismatches = 0;
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 50) begin
        $display("mismatch at %0t: %s", $time, msg);
      end
    endtask

    // v + round(sum / 2^(2F)), half rounds up
    function longint row_sum(longint v, longint c0, longint a, longint c1, longint b,
                             longint c2, longint c);
      longint acc;
      acc = c0 * a + c1 * b + c2 * c + (longint'(1) <<< (2 * QUAT_FRAC - 1));
      return v + (acc >>> (2 * QUAT_FRAC));
    endfunction

    function rot_t clamp_rot(input longint v, inout logic clip);
      if (v > ROT_MAX) begin
        clip = 1'b1;
        return ROT_HI;
      end
      if (v < ROT_MIN) begin
        clip = 1'b1;
        return ROT_LO;
      end
      return rot_t'(v);
    endfunction

    function rotated_t predict_rotation(rot_req_t it);
      longint w, x, y, z, vx, vy, vz;
      longint d00, e01, e02, e10, d11, e12, e20, e21, d22;
      rotated_t r;
      logic clip;
      w  = longint'(it.quat_w);
      x  = longint'(it.quat_x);
      y  = longint'(it.quat_y);
      z  = longint'(it.quat_z);
      vx = longint'(it.vec_x);
      vy = longint'(it.vec_y);
      vz = longint'(it.vec_z);
      clip = 1'b0;
      // matrix minus identity, 2F fraction bits
      d00 = -2 * (y * y + z * z);
      e01 = 2 * (x * y - w * z);
      e02 = 2 * (w * y + x * z);
      e10 = 2 * (x * y + w * z);
      d11 = -2 * (x * x + z * z);
      e12 = 2 * (y * z - w * x);
      e20 = 2 * (x * z - w * y);
      e21 = 2 * (w * x + y * z);
      d22 = -2 * (x * x + y * y);
      r.rot_x = clamp_rot(row_sum(vx, d00, vx, e01, vy, e02, vz), clip);
      r.rot_y = clamp_rot(row_sum(vy, e10, vx, d11, vy, e12, vz), clip);
      r.rot_z = clamp_rot(row_sum(vz, e20, vx, e21, vy, d22, vz), clip);
      r.clipped = clip;
      return r;
    endfunction

    function void note_input(rot_req_t it);
      expected_rot_q.push_back(predict_rotation(it));
    endfunction

    task check_result(rotated_t got);
      rotated_t want;
      if (expected_rot_q.size() == 0) begin
        report("result with no item pending");
      end else begin
        want = expected_rot_q.pop_front();
        if (got.rot_x !== want.rot_x)
          report($sformatf("rot_x got %0d expected %0d", got.rot_x, want.rot_x));
        if (got.rot_y !== want.rot_y)
          report($sformatf("rot_y got %0d expected %0d", got.rot_y, want.rot_y));
        if (got.rot_z !== want.rot_z)
          report($sformatf("rot_z got %0d expected %0d", got.rot_z, want.rot_z));
        if (got.clipped !== want.clipped)
          report($sformatf("clipped got %b expected %b", got.clipped, want.clipped));
      end
    endtask

    function int pending();
      return expected_rot_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  qvr_in_if #(.VEC_WIDTH(VEC_W)) in_ch ();
  qvr_out_if                     out_ch ();

  quaternion_vector_rotate #(
    .QUAT_FRAC_BITS(QUAT_FRAC),
    .VEC_WIDTH(VEC_W)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(in_ch),
    .rsp(out_ch)
  );

  rotation_checker rot_chk = new();

  // shared controls between the stimulus and the receiver
  int hold_left = 0;
  bit no_idle   = 1'b0;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // capture accepted items
  always @(posedge clk) begin
    rot_req_t seen;
    if (!rst && in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
      seen.quat_w = in_ch.quat_w;
      seen.quat_x = in_ch.quat_x;
      seen.quat_y = in_ch.quat_y;
      seen.quat_z = in_ch.quat_z;
      seen.vec_x  = in_ch.vec_x;
      seen.vec_y  = in_ch.vec_y;
      seen.vec_z  = in_ch.vec_z;
      rot_chk.note_input(seen);
    end
  end

  // check accepted results
  always @(posedge clk) begin
    rotated_t got;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.rot_x   = out_ch.rot_x;
      got.rot_y   = out_ch.rot_y;
      got.rot_z   = out_ch.rot_z;
      got.clipped = out_ch.clipped;
      rot_chk.check_result(got);
    end
  end

  // receiver: random back-pressure, long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (no_idle) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= 9);
      end
    end
  end

  function automatic rot_req_t mk(int w, int x, int y, int z, int vx, int vy, int vz);
    rot_req_t it;
    it.quat_w = quat_t'(w);
    it.quat_x = quat_t'(x);
    it.quat_y = quat_t'(y);
    it.quat_z = quat_t'(z);
    it.vec_x  = vec_t'(vx);
    it.vec_y  = vec_t'(vy);
    it.vec_z  = vec_t'(vz);
    return it;
  endfunction

  function automatic logic [15:0] corner_value();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      4: return 16'h0001;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic rot_req_t random_item();
    rot_req_t it;
    case ($urandom_range(2))
      // full-range patterns, clipping common
      0: it = mk($signed(16'($urandom)), $signed(16'($urandom)), $signed(16'($urandom)),
                 $signed(16'($urandom)), $signed(16'($urandom)), $signed(16'($urandom)),
                 $signed(16'($urandom)));
      // quaternion within +/-1.0, mostly unclipped
      1: it = mk(int'($urandom_range(32768)) - 16384, int'($urandom_range(32768)) - 16384,
                 int'($urandom_range(32768)) - 16384, int'($urandom_range(32768)) - 16384,
                 $signed(16'($urandom)), $signed(16'($urandom)), $signed(16'($urandom)));
      // corner values per field
      default: it = mk($signed(corner_value()), $signed(corner_value()),
                       $signed(corner_value()), $signed(corner_value()),
                       $signed(corner_value()), $signed(corner_value()),
                       $signed(corner_value()));
    endcase
    return it;
  endfunction

  // offer one item and hold it until accepted
  task automatic send_item(rot_req_t it);
    if (!no_idle && $urandom_range(99) < 9) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.quat_w <= it.quat_w;
    in_ch.quat_x <= it.quat_x;
    in_ch.quat_y <= it.quat_y;
    in_ch.quat_z <= it.quat_z;
    in_ch.vec_x  <= it.vec_x;
    in_ch.vec_y  <= it.vec_y;
    in_ch.vec_z  <= it.vec_z;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
  endtask

  // stimulus and end of run
  initial begin
    rst          <= 1'b1;
    in_ch.valid  <= 1'b0;
    in_ch.quat_w <= '0;
    in_ch.quat_x <= '0;
    in_ch.quat_y <= '0;
    in_ch.quat_z <= '0;
    in_ch.vec_x  <= '0;
    in_ch.vec_y  <= '0;
    in_ch.vec_z  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // identity and zero quaternion
    send_item(mk(16384, 0, 0, 0, 1, 2, 3));
    send_item(mk(16384, 0, 0, 0, 32767, -32768, 0));
    send_item(mk(0, 0, 0, 0, -32768, 32767, -1));
    // quarter turn about z, half turn about x
    send_item(mk(11585, 0, 0, 11585, 1000, 0, 0));
    send_item(mk(0, 16384, 0, 0, 5, 7, -9));
    // exact halves round toward plus infinity
    send_item(mk(0, 0, 8192, 0, 1, 0, 0));
    send_item(mk(0, 0, 8192, 0, -1, 0, 0));
    send_item(mk(0, 0, 8192, 0, 3, 5, -7));
    // field extremes, saturation on both rails
    send_item(mk(-32768, -32768, -32768, -32768, 32767, 32767, 32767));
    send_item(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
    send_item(mk(32767, 32767, 32767, 32767, 32767, -32768, 32767));
    send_item(mk(32767, 32767, 32767, 32767, -1, 1, -1));
    send_item(mk(-32768, 32767, -32768, 32767, -32768, 32767, -32768));
    send_item(mk(-1, -1, -1, -1, -1, -1, -1));
    send_item(mk(1, -1, 1, -1, 32767, 32767, -32768));
    send_item(mk(0, 0, 0, -32768, 32767, 32767, 32767));
    send_item(mk(-32768, 0, 0, 0, 32767, -32768, 32767));
    // non-unit quaternion scales the vector
    send_item(mk(0, 23170, 0, 0, 32767, 32767, 32767));
    send_item(mk(16384, 16384, 16384, 16384, 100, -200, 300));

    for (int n = 0; n < N_RANDOM; n++) begin
      // long receiver hold-off while items keep coming
      if (n == 400) hold_left = 80;
      // sender pause until the pipeline drains
      if (n == 800) begin
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (rot_chk.pending() != 0);
      end
      no_idle = (n >= 1000 && n < 1300);
      send_item(random_item());
    end
    in_ch.valid <= 1'b0;

    // drain, then allow for stray results
    do @(posedge clk); while (rot_chk.pending() != 0);
    repeat (20) @(posedge clk);
    if (rot_chk.mismatches == 0 && rot_chk.pending() == 0) begin
      $display("quaternion_vector_rotate_tb OK");
    end else begin
      $display("quaternion_vector_rotate_tb NOT OK");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("quaternion_vector_rotate_tb NOT OK");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/qvr_pkg.sv
rtl/core/qvr_in_if.sv
rtl/core/qvr_out_if.sv
rtl/core/qvr_matrix.sv
rtl/core/quaternion_vector_rotate.sv
sim/quaternion_vector_rotate_tb.sv
